/* src/ita_pkg.sv */
// ----------------------------------------------------------------------------
// ita_pkg
// Shared types, constants and the digit-to-character map of the integer to
// radix text converter.
// ----------------------------------------------------------------------------
package ita_pkg;

	localparam int VALUE_BITS_DEF = 32;
	localparam int CMD_DEPTH      = 2;
	localparam int OUT_DEPTH      = 4;
	localparam int DIV_BITS       = 8;

	localparam logic [7:0] BASE_MIN = 8'd2;
	localparam logic [7:0] BASE_MAX = 8'd36;
	localparam logic [7:0] BASE_DEC = 8'd10;

	localparam logic [6:0] CHAR_ZERO    = 7'h30;
	localparam logic [6:0] CHAR_MINUS   = 7'h2d;
	localparam logic [6:0] CHAR_ALPHA_0 = 7'h57;
	localparam logic [6:0] CHAR_NONE    = 7'h00;

	typedef struct packed {
		logic       bad;
		logic       sign;
		logic [5:0] base;
	} cmd_ctl_t;

	typedef struct packed {
		logic [6:0] ascii_char;
		logic       last;
		logic       bad_base;
	} res_t;

	function automatic logic [6:0] digit_char(input logic [5:0] r);
		if (r < 6'd10) begin
			return CHAR_ZERO + {1'b0, r};
		end
		return CHAR_ALPHA_0 + {1'b0, r};
	endfunction

endpackage

/* src/ita_ram.sv */
// ----------------------------------------------------------------------------
// ita_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ita_ram #(
	parameter int WIDTH = 7,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* src/ita_fifo.sv */
// ----------------------------------------------------------------------------
// ita_fifo
// Small sync queue with fill level; depth must be a power of two, unchecked.
// ----------------------------------------------------------------------------
module ita_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           wdata,
	output logic                       full,
	input  logic                       pop,
	output logic [WIDTH-1:0]           rdata,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] level
);

	localparam int AW = $clog2(DEPTH);
	localparam int LW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [AW-1:0]    wptr_q;
	logic [AW-1:0]    rptr_q;
	logic [LW-1:0]    level_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (level_q == LW'(DEPTH));
	assign empty   = (level_q == '0);
	assign level   = level_q;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			level_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= wptr_q + AW'(1);
			end
			if (do_pop) begin
				rptr_q <= rptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				level_q <= level_q + LW'(1);
			end else if (do_pop && !do_push) begin
				level_q <= level_q - LW'(1);
			end
		end
	end

endmodule

/* src/ita_front.sv */
// ----------------------------------------------------------------------------
// ita_front
// Input side: check the base, form the magnitude and sign flag, and queue the
// command for the conversion engine.
// ----------------------------------------------------------------------------
module ita_front #(
	parameter int VALUE_BITS = ita_pkg::VALUE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  logic [VALUE_BITS-1:0]  value,
	input  logic [7:0]             base,
	output logic                   cmd_valid,
	input  logic                   cmd_pop,
	output logic [VALUE_BITS-1:0]  cmd_mag,
	output ita_pkg::cmd_ctl_t      cmd_ctl
);

	import ita_pkg::*;

	localparam int CW = VALUE_BITS + $bits(cmd_ctl_t);

	cmd_ctl_t              ctl;
	logic [VALUE_BITS-1:0] mag;
	logic                  neg;
	logic [CW-1:0]         rd;
	logic                  empty;

	always_comb begin
		neg      = value[VALUE_BITS-1];
		mag      = neg ? (~value + VALUE_BITS'(1)) : value;
		ctl.bad  = (base < BASE_MIN) || (base > BASE_MAX);
		ctl.sign = neg && (base == BASE_DEC);
		ctl.base = base[5:0];
	end

	ita_fifo #(
		.WIDTH(CW),
		.DEPTH(CMD_DEPTH)
	) u_cmd_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata ({mag, ctl}),
		.full  (full),
		.pop   (cmd_pop),
		.rdata (rd),
		.empty (empty),
		.level ()
	);

	assign cmd_valid = !empty;
	assign cmd_mag   = rd[CW-1 -: VALUE_BITS];
	assign cmd_ctl   = cmd_ctl_t'(rd[$bits(cmd_ctl_t)-1:0]);

endmodule

/* src/ita_back.sv */
// ----------------------------------------------------------------------------
// ita_back
// Conversion engine: divide the magnitude by the base a byte of quotient bits
// per cycle, store the digits and a minus sign if any, then read them back
// reversed into the result queue.
// ----------------------------------------------------------------------------
module ita_back #(
	parameter int VALUE_BITS = ita_pkg::VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_pop,
	input  logic [VALUE_BITS-1:0] cmd_mag,
	input  ita_pkg::cmd_ctl_t     cmd_ctl,
	output logic                  empty,
	input  logic                  pop,
	output logic [6:0]            ascii_char,
	output logic                  last,
	output logic                  bad_base
);

	import ita_pkg::*;

	localparam int CHUNKS = (VALUE_BITS + DIV_BITS - 1) / DIV_BITS;
	localparam int QW     = CHUNKS * DIV_BITS;
	localparam int KW     = $clog2(CHUNKS + 1);
	localparam int AW     = $clog2(VALUE_BITS);
	localparam int CW     = $clog2(VALUE_BITS + 1);
	localparam int LW     = $clog2(OUT_DEPTH + 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DIV  = 2'd1;
	localparam logic [1:0] S_SIGN = 2'd2;
	localparam logic [1:0] S_EMIT = 2'd3;

	logic [1:0]    st_q;
	logic [QW-1:0] quo_q;
	logic [5:0]    rem_q;
	logic [5:0]    base_q;
	logic          sign_q;
	logic [KW-1:0] chunk_q;
	logic [CW-1:0] cnt_q;
	logic          rv_q;
	logic          rlast_q;

	logic [QW-1:0] quo_d;
	logic [6:0]    r;
	logic [5:0]    rem_d;
	logic          chunk_end;

	logic          we;
	logic [AW-1:0] waddr;
	logic [6:0]    wdata;
	logic [AW-1:0] raddr;
	logic [6:0]    rdata;
	logic          rd_issue;

	res_t          res_in;
	res_t          res_out;
	logic          res_push;
	logic [LW-1:0] level;
	logic          room;

	always_comb begin
		r     = {1'b0, rem_q};
		quo_d = quo_q;
		for (int i = 0; i < DIV_BITS; i++) begin
			r     = {r[5:0], quo_d[QW-1]};
			quo_d = {quo_d[QW-2:0], 1'b0};
			if (r >= {1'b0, base_q}) begin
				r        = r - {1'b0, base_q};
				quo_d[0] = 1'b1;
			end
		end
		rem_d = r[5:0];
	end

	assign chunk_end = (chunk_q == KW'(CHUNKS - 1));
	assign room      = (({1'b0, level} + (LW+1)'(rv_q)) < (LW+1)'(OUT_DEPTH));
	assign rd_issue  = (st_q == S_EMIT) && room;
	assign raddr     = AW'(cnt_q - CW'(1));

	always_comb begin
		we      = 1'b0;
		waddr   = AW'(cnt_q);
		wdata   = digit_char(rem_d);
		cmd_pop = 1'b0;
		if (st_q == S_DIV && chunk_end) begin
			we = 1'b1;
		end
		if (st_q == S_SIGN) begin
			we    = 1'b1;
			wdata = CHAR_MINUS;
		end
		if (st_q == S_IDLE && cmd_valid && !rv_q && (!cmd_ctl.bad || room)) begin
			cmd_pop = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= S_IDLE;
			quo_q   <= '0;
			rem_q   <= '0;
			base_q  <= '0;
			sign_q  <= 1'b0;
			chunk_q <= '0;
			cnt_q   <= '0;
			rv_q    <= 1'b0;
			rlast_q <= 1'b0;
		end else begin
			rv_q <= rd_issue;
			if (rd_issue) begin
				rlast_q <= (cnt_q == CW'(1));
			end
			unique case (st_q)
				S_IDLE: begin
					if (cmd_pop && !cmd_ctl.bad) begin
						quo_q   <= QW'(cmd_mag);
						rem_q   <= '0;
						base_q  <= cmd_ctl.base;
						sign_q  <= cmd_ctl.sign;
						chunk_q <= '0;
						cnt_q   <= '0;
						st_q    <= S_DIV;
					end
				end
				S_DIV: begin
					quo_q   <= quo_d;
					rem_q   <= rem_d;
					chunk_q <= chunk_q + KW'(1);
					if (chunk_end) begin
						cnt_q   <= cnt_q + CW'(1);
						rem_q   <= '0;
						chunk_q <= '0;
						if (quo_d == '0) begin
							st_q <= sign_q ? S_SIGN : S_EMIT;
						end
					end
				end
				S_SIGN: begin
					cnt_q <= cnt_q + CW'(1);
					st_q  <= S_EMIT;
				end
				S_EMIT: begin
					if (rd_issue) begin
						cnt_q <= cnt_q - CW'(1);
						if (cnt_q == CW'(1)) begin
							st_q <= S_IDLE;
						end
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	ita_ram #(
		.WIDTH(7),
		.DEPTH(VALUE_BITS)
	) u_digit_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_comb begin
		res_push = rv_q || (cmd_pop && cmd_ctl.bad);
		if (rv_q) begin
			res_in.ascii_char = rdata;
			res_in.last       = rlast_q;
			res_in.bad_base   = 1'b0;
		end else begin
			res_in.ascii_char = CHAR_NONE;
			res_in.last       = 1'b1;
			res_in.bad_base   = 1'b1;
		end
	end

	ita_fifo #(
		.WIDTH($bits(res_t)),
		.DEPTH(OUT_DEPTH)
	) u_res_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res_in),
		.full  (),
		.pop   (pop),
		.rdata (res_out),
		.empty (empty),
		.level (level)
	);

	assign ascii_char = res_out.ascii_char;
	assign last       = res_out.last;
	assign bad_base   = res_out.bad_base;

endmodule

/* src/integer_to_radix_ascii.sv */
// ----------------------------------------------------------------------------
// integer_to_radix_ascii
// Converts a signed integer to lower-case text in base 2..36, most
// significant character first, with a leading '-' in base ten only.
// ----------------------------------------------------------------------------
// Each transaction on the input queue yields one result per character, the
// final one marked by last; a base outside 2..36 yields a single result with
// bad_base set and character zero. Up to two inputs wait ahead of the
// converter and up to four results wait behind it. Each digit is found by
// dividing the magnitude by the base (the divider retires eight quotient bits
// per cycle); a minus sign is stored after the digits when needed, and the
// digit RAM is then read back in reverse order while the result queue has
// room. Conversions are carried out one at a time.
// ----------------------------------------------------------------------------
module integer_to_radix_ascii #(
	parameter int VALUE_BITS = ita_pkg::VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [VALUE_BITS-1:0] value,
	input  logic [7:0]            base,
	output logic                  empty,
	input  logic                  pop,
	output logic [6:0]            ascii_char,
	output logic                  last,
	output logic                  bad_base
);

	import ita_pkg::*;

	logic                  cmd_valid;
	logic                  cmd_pop;
	logic [VALUE_BITS-1:0] cmd_mag;
	cmd_ctl_t              cmd_ctl;

	ita_front #(
		.VALUE_BITS(VALUE_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.value    (value),
		.base     (base),
		.cmd_valid(cmd_valid),
		.cmd_pop  (cmd_pop),
		.cmd_mag  (cmd_mag),
		.cmd_ctl  (cmd_ctl)
	);

	ita_back #(
		.VALUE_BITS(VALUE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd_mag   (cmd_mag),
		.cmd_ctl   (cmd_ctl),
		.empty     (empty),
		.pop       (pop),
		.ascii_char(ascii_char),
		.last      (last),
		.bad_base  (bad_base)
	);

endmodule
